// ===== rtl/pd_pkg.sv =====
// Shared types, constants and helper functions for the percent decoder.
// Used by pd_front, pd_queue, pd_back and percent_decoder; no dependencies.
`timescale 1ns / 1ps

package pd_pkg;

    // Character codes that the decoder recognizes.
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Escape state of the front end, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,   // nothing pending
        PH_PCT  = 3'b010,   // a '%' is pending
        PH_DIG  = 3'b100    // a '%' and one hex digit are pending
    } phase_t;

    // One command for the back end: up to three bytes and an end-of-string flag.
    typedef struct packed {
        logic        last;   // the final byte of this command ends the string
        logic [1:0]  cnt;    // number of valid bytes, 1 to 3
        logic [2:0][7:0] data; // bytes in output order, data[0] first
    } cmd_t;

    // Hex digit classification: bit 4 set when the character is a hex digit,
    // bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/pd_front.sv =====
// Front end of the percent decoder: accepts raw bytes, tracks escape state
// and turns each byte into a command of zero to three output bytes.
// Depends on pd_pkg.
`timescale 1ns / 1ps

module pd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [7:0] in_byte
    input  logic            s_axis_tlast,   // in_last
    input  logic            q_full,
    output logic            push,
    output pd_pkg::cmd_t    push_cmd
);

    pd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]     held_reg, held_next;
    logic           accept;
    logic [4:0]     hv;
    logic [4:0]     hi;
    logic           is_hex;
    logic           is_pct;
    logic [7:0]     b;
    logic [1:0]     n;
    logic [2:0][7:0] bytes;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign b             = s_axis_tdata;
    assign hv            = pd_pkg::hex_value(b);
    assign hi            = pd_pkg::hex_value(held_reg);
    assign is_hex        = hv[4];
    assign is_pct        = (b == pd_pkg::PCT_CHAR);

    // Classify the byte against the pending escape and collect output bytes.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        n          = 2'd0;
        bytes      = '0;
        case (phase_reg)
            pd_pkg::PH_PCT:
            begin
                if (is_hex) begin
                    held_next  = b;
                    phase_next = pd_pkg::PH_DIG;
                end else if (is_pct) begin
                    bytes[n] = pd_pkg::PCT_CHAR;
                    n        = n + 2'd1;
                end else begin
                    bytes[n]   = pd_pkg::PCT_CHAR;
                    n          = n + 2'd1;
                    bytes[n]   = b;
                    n          = n + 2'd1;
                    phase_next = pd_pkg::PH_IDLE;
                end
            end
            pd_pkg::PH_DIG:
            begin
                if (is_hex) begin
                    bytes[n]   = {hi[3:0], hv[3:0]};
                    n          = n + 2'd1;
                    phase_next = pd_pkg::PH_IDLE;
                end else begin
                    bytes[n] = pd_pkg::PCT_CHAR;
                    n        = n + 2'd1;
                    bytes[n] = held_reg;
                    n        = n + 2'd1;
                    if (is_pct) begin
                        phase_next = pd_pkg::PH_PCT;
                    end else begin
                        bytes[n]   = b;
                        n          = n + 2'd1;
                        phase_next = pd_pkg::PH_IDLE;
                    end
                end
                if (phase_next != pd_pkg::PH_DIG) begin
                    held_next = 8'd0;
                end
            end
            default:
            begin
                // Idle, and any code that cannot arise, behaves as idle.
                if (is_pct) begin
                    phase_next = pd_pkg::PH_PCT;
                end else begin
                    bytes[n]   = b;
                    n          = n + 2'd1;
                    phase_next = pd_pkg::PH_IDLE;
                end
            end
        endcase

        // At end of string, flush whatever is still pending literally.
        if (s_axis_tlast) begin
            if (phase_next == pd_pkg::PH_PCT) begin
                bytes[n] = pd_pkg::PCT_CHAR;
                n        = n + 2'd1;
            end else if (phase_next == pd_pkg::PH_DIG) begin
                bytes[n] = pd_pkg::PCT_CHAR;
                n        = n + 2'd1;
                bytes[n] = held_next;
                n        = n + 2'd1;
            end
            phase_next = pd_pkg::PH_IDLE;
            held_next  = 8'd0;
        end
    end

    // Command toward the queue; a byte that produces nothing is not queued.
    assign push          = accept && (n != 2'd0);
    assign push_cmd.last = s_axis_tlast;
    assign push_cmd.cnt  = n;
    assign push_cmd.data = bytes;

    // Escape state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= pd_pkg::PH_IDLE;
            held_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/pd_queue.sv =====
// Two-entry command queue between the front and back ends of the decoder.
// Depends on pd_pkg.
`timescale 1ns / 1ps

module pd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pd_pkg::cmd_t    push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output pd_pkg::cmd_t    head
);

    pd_pkg::cmd_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/pd_back.sv =====
// Back end of the percent decoder: walks the head command byte by byte into
// a registered output stream. Depends on pd_pkg.
`timescale 1ns / 1ps

module pd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  pd_pkg::cmd_t    head,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       load;
    logic       final_byte;

    assign load       = !valid_reg || m_axis_tready;
    assign final_byte = (idx_reg == 2'(head.cnt - 2'd1));
    assign pop        = load && head_valid && final_byte;

    // Select the next byte of the head command when the output register frees.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                data_next = head.data[idx_reg];
                last_next = final_byte && head.last;
                idx_next  = final_byte ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ===== rtl/percent_decoder.sv =====
// Streaming URL percent decoder.
// Slave channel s_axis: one raw byte of the encoded string per transaction,
// tlast on the final byte of a string. Master channel m_axis: one decoded
// byte per transaction, tlast on the final decoded byte of the string.
// A '%' and two hex digits become one byte; a broken escape passes through
// literally and the following bytes are examined again; at end of string a
// pending '%' and digit are flushed literally.
// An accepted byte's command is written into the command queue, and its bytes
// then pass through the output register onto m_axis. Throughput: one input
// transaction and one output transaction per cycle while the queue is not
// full and the receiver is ready. An input byte yields zero to three output
// bytes; a three-byte burst holds the output for three transactions and backs
// up the input through a two-entry command queue, which sets how far the
// front end can run ahead. When the receiver stalls, the output register
// holds its transaction and the input keeps flowing until the queue fills.
// Reset: no escape pending, queue empty, no output transaction valid.
// Depends on pd_pkg, pd_front, pd_queue and pd_back.
`timescale 1ns / 1ps

module percent_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // out_last
);

    logic         push;
    pd_pkg::cmd_t push_cmd;
    logic         q_full;
    logic         pop;
    logic         head_valid;
    pd_pkg::cmd_t head;

    // Byte classification and escape tracking.
    pd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // Command queue between the two halves.
    pd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Byte-serial output.
    pd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for percent_decoder: drives encoded strings on s_axis,
// predicts the decoded bytes and checks every m_axis transaction against them.
// Depends on pd_pkg and the percent_decoder RTL.
`timescale 1ns / 1ps

module testbench;

    // One decoded byte as it should appear on m_axis.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;   // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;   // out_last

    // Decoded bytes still owed by the block, oldest first.
    dec_byte_t      expected_bytes[$];
    // Encoded string waiting to be sent.
    logic [7:0]     text[$];
    // Escape state of the decoder as the bench sees it.
    pd_pkg::phase_t esc_phase;
    logic [7:0]     esc_digit;
    int unsigned    mismatches;
    // When set, neither the sender nor the receiver inserts idle cycles.
    bit             calm;

    percent_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous upper bound on the whole run.
    initial
    begin
        #500000;
        $display("FAIL");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (calm) return 0;
        if (k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Value of a hex digit; letters of either case have low nibble 1 to 6.
    function automatic logic [3:0] nibble(input logic [7:0] c);
        if (c <= "9") return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    function automatic logic [7:0] random_hex();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("A" + k - 10);
        return 8'("a" + k - 16);
    endfunction

    // Advance the decoder state by one raw byte and queue the bytes it releases.
    function automatic void decode_model(input logic [7:0] b, input logic last);
        logic [7:0] obuf[4];
        int         n;
        n = 0;
        case (esc_phase)
            pd_pkg::PH_PCT:
            begin
                if (is_hex(b)) begin
                    esc_digit = b;
                    esc_phase = pd_pkg::PH_DIG;
                end else if (b == pd_pkg::PCT_CHAR) begin
                    // A second '%' releases the first and stays pending itself.
                    obuf[n] = pd_pkg::PCT_CHAR; n++;
                end else begin
                    obuf[n] = pd_pkg::PCT_CHAR; n++;
                    obuf[n] = b; n++;
                    esc_phase = pd_pkg::PH_IDLE;
                end
            end
            pd_pkg::PH_DIG:
            begin
                if (is_hex(b)) begin
                    obuf[n] = {nibble(esc_digit), nibble(b)}; n++;
                    esc_phase = pd_pkg::PH_IDLE;
                end else begin
                    obuf[n] = pd_pkg::PCT_CHAR; n++;
                    obuf[n] = esc_digit; n++;
                    if (b == pd_pkg::PCT_CHAR) begin
                        esc_phase = pd_pkg::PH_PCT;
                    end else begin
                        obuf[n] = b; n++;
                        esc_phase = pd_pkg::PH_IDLE;
                    end
                end
                if (esc_phase != pd_pkg::PH_DIG) esc_digit = 8'h00;
            end
            default:
            begin
                if (b == pd_pkg::PCT_CHAR) begin
                    esc_phase = pd_pkg::PH_PCT;
                end else begin
                    obuf[n] = b; n++;
                end
            end
        endcase

        // End of string flushes whatever escape is still open.
        if (last) begin
            if (esc_phase == pd_pkg::PH_PCT) begin
                obuf[n] = pd_pkg::PCT_CHAR; n++;
            end else if (esc_phase == pd_pkg::PH_DIG) begin
                obuf[n] = pd_pkg::PCT_CHAR; n++;
                obuf[n] = esc_digit; n++;
            end
            esc_phase = pd_pkg::PH_IDLE;
            esc_digit = 8'h00;
        end

        for (int i = 0; i < n; i++) begin
            expected_bytes.push_back('{data: obuf[i], last: last && (i == n - 1)});
        end
    endfunction

    // Offer one raw byte on s_axis and wait for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge clk); while (!s_axis_tready);
        decode_model(b, last);
    endtask

    task automatic release_input();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Send the prepared string, marking its final byte.
    task automatic send_text();
        for (int i = 0; i < text.size(); i++) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    // Build a string mostly of valid escapes and plain bytes, with some broken
    // escapes and the occasional escape left open at the end.
    task automatic build_string(input int max_len);
        int n;
        int k;
        text.delete();
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                text.push_back(pd_pkg::PCT_CHAR);
                text.push_back(random_hex());
                text.push_back(random_hex());
            end else if (k < 50) begin
                text.push_back(pd_pkg::PCT_CHAR);
                text.push_back(random_hex());
                text.push_back(8'($urandom_range(0, 255)));
            end else if (k < 58) begin
                text.push_back(pd_pkg::PCT_CHAR);
                text.push_back(8'($urandom_range(0, 255)));
            end else if (k < 62) begin
                text.push_back(pd_pkg::PCT_CHAR);
                text.push_back(pd_pkg::PCT_CHAR);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        k = $urandom_range(0, 9);
        if (k == 0) begin
            text.push_back(pd_pkg::PCT_CHAR);
        end else if (k == 1) begin
            text.push_back(pd_pkg::PCT_CHAR);
            text.push_back(random_hex());
        end
    endtask

    task automatic send_literal(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_text();
    endtask

    // Valid escapes, broken escapes, open escapes at end and byte extremes.
    task automatic test_directed();
        send_literal("%41");
        send_literal("%%4f");
        text.delete();
        text.push_back(pd_pkg::PCT_CHAR);
        text.push_back("f");
        text.push_back("F");
        text.push_back(8'h00);
        send_text();
        send_literal("%4G");
        send_literal("%4%");
        send_literal("%:");
        send_literal("%");
        send_literal("%a");
        text.delete();
        text.push_back(8'hFF);
        send_text();
        send_literal("%00");
    endtask

    task automatic test_random_strings(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            build_string(6);
            sent += text.size();
            send_text();
        end
    endtask

    // Strings with no idle cycles on either side.
    task automatic test_back_to_back(input int items);
        calm = 1'b1;
        test_random_strings(items);
        calm = 1'b0;
    endtask

    // Unstructured bytes with '%' and hex digits mixed in and random ends.
    task automatic test_noise(input int items);
        int         k;
        logic [7:0] b;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 3);
            if (k == 0) b = pd_pkg::PCT_CHAR;
            else if (k == 1) b = random_hex();
            else b = 8'($urandom_range(0, 255));
            send_byte(b, $urandom_range(0, 7) == 0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // The sender waits for every owed byte before each string.
    task automatic test_drain_pauses(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            release_input();
            wait (expected_bytes.size() == 0);
            build_string(4);
            sent += text.size();
            send_text();
        end
    endtask

    // Receiver: random stalls on m_axis.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Compare each output transaction with the oldest owed byte.
    always @(posedge clk)
    begin
        dec_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %02h last %0b", $realtime,
                             m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected byte %02h last %0b, got %02h last %0b",
                                 $realtime, want.data, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // Reset, run the tests in turn, then drain and report.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        calm          = 1'b0;
        mismatches    = 0;
        esc_phase     = pd_pkg::PH_IDLE;
        esc_digit     = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_strings(200);
        test_back_to_back(60);
        test_noise(50);
        test_drain_pauses(50);

        release_input();
        wait (expected_bytes.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
